[rtl/usage_accounting_with_pressure_alarm_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the usage accounting unit
// Concurrent checks, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef USAGE_ACCOUNTING_WITH_PRESSURE_ALARM_UNIT_DEFINES_SVH
`define USAGE_ACCOUNTING_WITH_PRESSURE_ALARM_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define UAPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");
// next-cycle implication
`define UAPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");
`else
`define UAPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define UAPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/uapa_pkg.sv]
// ----------------------------------------------------------------------------
// uapa_pkg
// Types, constants and helpers shared by the usage accounting unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uapa_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int COUNT_WIDTH = 48;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int THRESH_W    = 48;

   // register index, taken from paddr above the 8-byte offset
   localparam logic [CSR_ADDR_W-4:0] REG_THRESHOLD = '0;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SLOT_IDX_W-1:0]  slot_idx_type;
   typedef logic [THRESH_W-1:0]    thresh_type;

   typedef struct packed {
      logic        mode;
      logic [3:0]  component_index;
      logic [31:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [47:0] total_usage;
      logic [47:0] total_peak;
      logic [47:0] slot_usage;
      logic [47:0] slot_peak;
      logic        pressure_event;
      logic        unknown_slot;
      logic        underflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic read;
      logic calc;
      logic update;
   } ctrl_cmd_type;

   // counter value onto a 48-bit result field
   function automatic logic [47:0] to_out48(input count_type c);
      logic [63:0] w;
      w = 64'(c);
      return w[47:0];
   endfunction

endpackage

`default_nettype wire

[rtl/usage_accounting_with_pressure_alarm_unit.sv]
// The result strobe rises after the item has passed the controller's read, compute and
// update states over the slot store; the block takes no new item until that sequence is
// done, and busy falls in the cycle that carries the result.
// The result is shown for one cycle and cannot be held off by the receiver.
// Reset (synchronous) clears all slot valid marks, totals, peaks, the alarm and the
// threshold; the block takes items once reset is low.
// ----------------------------------------------------------------------------
// usage_accounting_with_pressure_alarm_unit
// Per-slot and global usage accounting with a one-shot pressure alarm.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usage_accounting_with_pressure_alarm_unit_defines.svh"

module usage_accounting_with_pressure_alarm_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire uapa_pkg::req_type                   req_item,
   output logic                                     rsp_valid,
   output uapa_pkg::rsp_type                        rsp_item,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [uapa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [uapa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [uapa_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   uapa_pkg::ctrl_cmd_type cmd;
   uapa_pkg::thresh_type   thr_value;
   logic                   thr_write;
   logic                   thr_hit;

   assign thr_hit   = (paddr[uapa_pkg::CSR_ADDR_W-1:3] == uapa_pkg::REG_THRESHOLD);
   assign thr_write = psel && penable && pwrite && thr_hit;
   assign pready    = 1'b1;
   assign prdata    = thr_hit ? uapa_pkg::CSR_DATA_W'(thr_value) : '0;

   uapa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   uapa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .thr_write (thr_write),
      .thr_wdata (pwdata[uapa_pkg::THRESH_W-1:0]),
      .thr_value (thr_value),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `UAPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `UAPA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `UAPA_ASSERT_SAME(a_peak_bound, clock, reset, rsp_valid, rsp_item.total_peak >= rsp_item.total_usage)
   `UAPA_ASSERT_SAME(a_unknown_clear, clock, reset, rsp_valid && rsp_item.unknown_slot, (rsp_item.slot_usage == '0) && (rsp_item.slot_peak == '0) && !rsp_item.pressure_event && !rsp_item.underflow)

endmodule

`default_nettype wire

[rtl/uapa_ctrl.sv]
// ----------------------------------------------------------------------------
// uapa_ctrl
// Sequencer: accept, read slot, compute, update and issue the result.
// ----------------------------------------------------------------------------
`default_nettype none

module uapa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output uapa_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CALC = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ: state_in = ST_CALC;
         ST_CALC: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.read   = (state_ff == ST_READ);
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.update = (state_ff == ST_UPD);

endmodule

`default_nettype wire

[rtl/uapa_dpath.sv]
// ----------------------------------------------------------------------------
// uapa_dpath
// Slot store, global counters, threshold register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uapa_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire uapa_pkg::ctrl_cmd_type cmd,
   input  wire uapa_pkg::req_type      req_item,
   input  wire logic                   thr_write,
   input  wire uapa_pkg::thresh_type   thr_wdata,
   output uapa_pkg::thresh_type        thr_value,
   output logic                        rsp_valid,
   output uapa_pkg::rsp_type           rsp_item
);

   localparam int CW = uapa_pkg::COUNT_WIDTH;

   // captured item
   logic        mode_ff;
   logic [3:0]  idx_raw_ff;
   logic [31:0] bytes_ff;

   // slot store; valid bits stand in for the zero reset
   logic [uapa_pkg::SLOT_COUNT-1:0] valid_ff;
   uapa_pkg::count_type use_mem_ff  [uapa_pkg::SLOT_COUNT];
   uapa_pkg::count_type peak_mem_ff [uapa_pkg::SLOT_COUNT];

   uapa_pkg::count_type total_ff;
   uapa_pkg::count_type gpeak_ff;
   uapa_pkg::thresh_type thr_ff;
   logic alarm_ff;

   // read stage
   logic                in_range_ff;
   logic                old_vld_ff;
   uapa_pkg::count_type old_use_ff;
   uapa_pkg::count_type old_peak_ff;

   // compute stage
   uapa_pkg::count_type nu_ff, nu_in;
   uapa_pkg::count_type take_ff, take_in;
   uapa_pkg::count_type nta_ff, nta_in;
   logic act_alloc_ff, act_alloc_in;
   logic act_rel_ff, act_rel_in;
   logic unknown_ff, unknown_in;
   logic under_ff, under_in;

   // update stage
   uapa_pkg::count_type new_total_in;
   uapa_pkg::count_type new_gpeak_in;
   uapa_pkg::count_type new_speak_in;
   logic                press_in;
   logic                show_in;

   uapa_pkg::rsp_type rsp_item_ff;
   logic              rsp_valid_ff;

   uapa_pkg::slot_idx_type sidx;
   logic                   in_range;
   logic                   active;
   logic [CW:0]            alloc_sum;
   logic [CW:0]            tot_sum;
   logic [CW:0]            rel_diff;
   logic [CW:0]            tot_diff;
   uapa_pkg::count_type    nt_rel;

   assign sidx     = uapa_pkg::SLOT_IDX_W'(idx_raw_ff);
   assign in_range = (32'(idx_raw_ff) < uapa_pkg::SLOT_COUNT);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_item.mode;
         idx_raw_ff <= req_item.component_index;
         bytes_ff   <= req_item.byte_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         in_range_ff <= in_range;
         old_vld_ff  <= in_range && valid_ff[sidx];
         old_use_ff  <= (in_range && valid_ff[sidx]) ? use_mem_ff[sidx]  : '0;
         old_peak_ff <= (in_range && valid_ff[sidx]) ? peak_mem_ff[sidx] : '0;
      end
   end

   // compute: saturating adds and the clamped slot release
   always_comb begin
      active    = in_range_ff && (bytes_ff != '0);
      alloc_sum = {1'b0, old_use_ff} + (CW+1)'(bytes_ff);
      tot_sum   = {1'b0, total_ff} + (CW+1)'(bytes_ff);
      rel_diff  = {1'b0, old_use_ff} - (CW+1)'(bytes_ff);

      act_alloc_in = active && (mode_ff == uapa_pkg::MODE_ALLOC);
      act_rel_in   = active && (mode_ff == uapa_pkg::MODE_RELEASE) && old_vld_ff;
      unknown_in   = active && (mode_ff == uapa_pkg::MODE_RELEASE) && !old_vld_ff;
      under_in     = act_rel_in && rel_diff[CW];

      nta_in  = tot_sum[CW] ? uapa_pkg::COUNT_MAX : tot_sum[CW-1:0];
      take_in = rel_diff[CW] ? old_use_ff : CW'(bytes_ff);

      if (act_alloc_in) begin
         nu_in = alloc_sum[CW] ? uapa_pkg::COUNT_MAX : alloc_sum[CW-1:0];
      end else if (act_rel_in) begin
         nu_in = rel_diff[CW] ? '0 : rel_diff[CW-1:0];
      end else begin
         nu_in = old_use_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         nu_ff        <= nu_in;
         take_ff      <= take_in;
         nta_ff       <= nta_in;
         act_alloc_ff <= act_alloc_in;
         act_rel_ff   <= act_rel_in;
         unknown_ff   <= unknown_in;
         under_ff     <= under_in;
      end
   end

   // update: total after release, peaks, one-shot alarm
   always_comb begin
      tot_diff = {1'b0, total_ff} - {1'b0, take_ff};
      nt_rel   = tot_diff[CW] ? '0 : tot_diff[CW-1:0];

      if (act_alloc_ff) begin
         new_total_in = nta_ff;
      end else if (act_rel_ff) begin
         new_total_in = nt_rel;
      end else begin
         new_total_in = total_ff;
      end

      new_gpeak_in = (act_alloc_ff && (nta_ff > gpeak_ff)) ? nta_ff : gpeak_ff;
      new_speak_in = (act_alloc_ff && (nu_ff > old_peak_ff)) ? nu_ff : old_peak_ff;
      press_in     = act_alloc_ff && (thr_ff != '0) && !alarm_ff &&
                     (64'(nta_ff) >= 64'(thr_ff));
      show_in      = in_range_ff && (old_vld_ff || act_alloc_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.update && (act_alloc_ff || act_rel_ff)) begin
         use_mem_ff[sidx]  <= nu_ff;
         peak_mem_ff[sidx] <= new_speak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         gpeak_ff     <= '0;
         thr_ff       <= '0;
         alarm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.update) begin
            total_ff <= new_total_in;
            gpeak_ff <= new_gpeak_in;
            if (act_alloc_ff) valid_ff[sidx] <= 1'b1;
         end
         // a threshold write re-arms the alarm
         if (thr_write) begin
            thr_ff   <= thr_wdata;
            alarm_ff <= 1'b0;
         end else if (cmd.update && press_in) begin
            alarm_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_item_ff.total_usage    <= uapa_pkg::to_out48(new_total_in);
         rsp_item_ff.total_peak     <= uapa_pkg::to_out48(new_gpeak_in);
         rsp_item_ff.slot_usage     <= show_in ? uapa_pkg::to_out48(nu_ff) : '0;
         rsp_item_ff.slot_peak      <= show_in ? uapa_pkg::to_out48(new_speak_in) : '0;
         rsp_item_ff.pressure_event <= press_in;
         rsp_item_ff.unknown_slot   <= unknown_ff;
         rsp_item_ff.underflow      <= under_ff;
      end
   end

   assign thr_value = thr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
